FILE: hw/rtl/dups_pkg.sv
// ----------------------------------------------------------------------------
// dups_pkg
// Shared types and constants of the decay-usage priority scheduler.
// ----------------------------------------------------------------------------
package dups_pkg;

    localparam int MAX_SLOTS   = 16;
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W       = $clog2(MAX_SLOTS + 1);

    localparam int USAGE_W     = 16;
    localparam int PRIO_W      = 13;
    localparam int BASE_W      = 7;
    localparam int ACTIVE_W    = 5;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int INDEX_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_PRIORITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOTS  = 2'd1;

    localparam int DECAY       = 10;
    localparam logic [15:0] RECIP_10    = 16'hCCCD;
    localparam int RECIP_SHIFT = 19;

    typedef struct packed {
        logic [USAGE_W-1:0] usage;
        logic [PRIO_W-1:0]  prio;
    } t_entry;

    typedef struct packed {
        logic              chosen;
        logic [BASE_W-1:0] base;
    } t_upd_ctrl;

endpackage

FILE: hw/rtl/dups_cell.sv
// ----------------------------------------------------------------------------
// dups_cell
// One slot cell of the ring: holds a usage count and a priority and takes
// its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module dups_cell
    import dups_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: hw/rtl/dups_update.sv
// ----------------------------------------------------------------------------
// dups_update
// Usage decay and priority recomputation for the entry at the ring head.
// ----------------------------------------------------------------------------
module dups_update
    import dups_pkg::*;
(
    input  t_entry    i_entry,
    input  t_upd_ctrl i_ctrl,
    output t_entry    o_entry
);

    logic [USAGE_W+1:0] sum;
    logic [USAGE_W-1:0] usage;
    logic [31:0]        prod;
    logic [PRIO_W-1:0]  quot;

    always_comb begin
        sum = {2'b00, i_entry.usage}
            + (i_ctrl.chosen ? (USAGE_W+2)'(i_ctrl.base) : '0)
            - (USAGE_W+2)'(DECAY);
        if (sum[USAGE_W+1]) begin
            usage = '0;
        end else if (sum[USAGE_W]) begin
            usage = '1;
        end else begin
            usage = sum[USAGE_W-1:0];
        end
        prod = 32'(usage) * 32'(RECIP_10);
        quot = prod[RECIP_SHIFT+PRIO_W-1:RECIP_SHIFT];
        o_entry.usage = usage;
        o_entry.prio  = PRIO_W'(i_ctrl.base) + quot;
    end

endmodule

FILE: hw/rtl/decay_usage_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// decay_usage_priority_scheduler_unit
// Decay-usage priority scheduler built as a ring of slot cells.
//
// A transaction is started by raising start while busy is low. With i_tick
// high the block makes two full turns of its ring of MAX_SLOTS cells. In the
// first turn the head cell is compared against the best priority so far and
// the lowest-priority active slot is chosen, lowest index first. In the
// second turn each active slot's usage and priority are updated at the head
// and one result row is produced for it, in slot order, with o_last_row on
// the final active slot. Inactive slots pass round unchanged.
// Each row is on the o_ ports for one cycle while o_valid is high; the
// receiver cannot stall. A tick keeps busy high through the two ring
// turns, the scan turn and then the emit turn. With all MAX_SLOTS slots
// active, the last row is taken at the same edge that can take the next
// transaction. A transaction with i_tick low is taken and produces no rows.
// Configuration writes through i_cfg_we, i_cfg_idx and i_cfg_data take
// effect at once; the user makes them only while the block is idle, as
// the block itself does not enforce this.
// Reset clears all usage counts and priorities, sets the base priority to
// zero and the number of active slots to one.
// ----------------------------------------------------------------------------
module decay_usage_priority_scheduler_unit
    import dups_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  i_tick,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [INDEX_W-1:0]    o_slot_index,
    output logic [PRIO_W-1:0]     o_slot_priority,
    output logic [USAGE_W-1:0]    o_slot_usage,
    output logic                  o_was_chosen,
    output logic                  o_last_row
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(MAX_SLOTS - 1);

    logic [1:0]          r_state, n_state;
    logic [SLOT_W-1:0]   r_pos, n_pos;
    logic [SLOT_W-1:0]   r_pick, n_pick;
    logic [PRIO_W-1:0]   r_best, n_best;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [BASE_W-1:0]   r_base;
    logic [ACTIVE_W-1:0] r_active;

    logic                r_valid;
    logic [INDEX_W-1:0]  r_index;
    t_entry              r_row;
    logic                r_chosen;
    logic                r_last;

    t_entry              cell_q [MAX_SLOTS];
    t_entry              head;
    t_entry              upd_entry;
    t_entry              ring_in;
    t_upd_ctrl           upd_ctrl;
    logic                shift;
    logic                pos_active;
    logic [CNT_W-1:0]    slots_use;

    always_comb begin
        if (r_active == '0) begin
            slots_use = CNT_W'(1);
        end else if (int'(r_active) > MAX_SLOTS) begin
            slots_use = CNT_W'(MAX_SLOTS);
        end else begin
            slots_use = CNT_W'(r_active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_active <= ACTIVE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_PRIORITY: r_base   <= i_cfg_data[BASE_W-1:0];
                REG_ACTIVE_SLOTS:  r_active <= i_cfg_data[ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    assign head       = cell_q[0];
    assign shift      = (r_state == ST_SCAN) || (r_state == ST_EMIT);
    assign pos_active = CNT_W'(r_pos) < r_n;

    assign upd_ctrl.chosen = (r_pos == r_pick);
    assign upd_ctrl.base   = r_base;

    dups_update u_update (
        .i_entry (head),
        .i_ctrl  (upd_ctrl),
        .o_entry (upd_entry)
    );

    assign ring_in = ((r_state == ST_EMIT) && pos_active) ? upd_entry : head;

    genvar k;
    generate
        for (k = 0; k < MAX_SLOTS; k++) begin : g_cell
            t_entry cell_d;
            if (k == MAX_SLOTS - 1) begin : g_tail
                assign cell_d = ring_in;
            end else begin : g_body
                assign cell_d = cell_q[k+1];
            end
            dups_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_entry (cell_d),
                .o_entry (cell_q[k])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_pick  = r_pick;
        n_best  = r_best;
        n_n     = r_n;
        case (r_state)
            ST_IDLE: begin
                if (start && i_tick) begin
                    n_state = ST_SCAN;
                    n_pos   = '0;
                    n_pick  = '0;
                    n_n     = slots_use;
                end
            end
            ST_SCAN: begin
                if (pos_active && ((r_pos == '0) || (head.prio < r_best))) begin
                    n_best = head.prio;
                    n_pick = r_pos;
                end
                n_pos = r_pos + SLOT_W'(1);
                if (r_pos == LAST_POS) begin
                    n_state = ST_EMIT;
                    n_pos   = '0;
                end
            end
            ST_EMIT: begin
                n_pos = r_pos + SLOT_W'(1);
                if (r_pos == LAST_POS) begin
                    n_state = ST_IDLE;
                    n_pos   = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_pick  <= '0;
            r_n     <= CNT_W'(1);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_pick  <= n_pick;
            r_n     <= n_n;
            r_valid <= (r_state == ST_EMIT) && pos_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        if ((r_state == ST_EMIT) && pos_active) begin
            r_index  <= INDEX_W'(r_pos);
            r_row    <= upd_entry;
            r_chosen <= (r_pos == r_pick);
            r_last   <= (CNT_W'(r_pos) + CNT_W'(1) == r_n);
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_slot_index    = r_index;
    assign o_slot_priority = r_row.prio;
    assign o_slot_usage    = r_row.usage;
    assign o_was_chosen    = r_chosen;
    assign o_last_row      = r_last;

    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state) == ST_EMIT)
        else $error("Result strobe without a preceding emit cycle.");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |=> !r_valid)
        else $error("Result row follows the last row of a transaction.");

    a_scan_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_pos == LAST_POS) |=> (r_state == ST_EMIT && r_pos == '0))
        else $error("Scan turn did not hand over to the emit turn.");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (CNT_W'(r_pick) < r_n))
        else $error("Chosen slot lies outside the active slots.");

endmodule
